>>> sv/stq_pkg.sv
// stq_pkg: shared constants, codes and state type for the sorted timer queue
// no dependencies
package stq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 64;
  localparam int unsigned ID_BITS_DEF     = 8;
  localparam int unsigned TIME_BITS_DEF   = 48;

  // request codes
  typedef enum logic [1:0] {
    REQ_SCHEDULE = 2'd0,
    REQ_CANCEL   = 2'd1,
    REQ_POLL     = 2'd2,
    REQ_UNUSED   = 2'd3
  } req_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_EXPIRED  = 3'd1,
    ST_NONE     = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_CHK,
    S_DN_RD,
    S_DN_WR,
    S_POS_RD,
    S_POS_CHK,
    S_UP_RD,
    S_UP_WR,
    S_POLL_RD,
    S_POLL_CHK,
    S_RESP
  } state_t;

endpackage

>>> sv/stq_if.sv
// stq_in_if / stq_out_if: valid-ready channels of the sorted timer queue
// no dependencies
interface stq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  timer_id;
  logic [31:0] delay_ms;
  logic [15:0] elapsed_ms;

  modport source (output valid, req_type, timer_id, delay_ms, elapsed_ms, input ready);
  modport sink   (input valid, req_type, timer_id, delay_ms, elapsed_ms, output ready);
endinterface

interface stq_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] expired_id;
  logic       is_last;

  modport source (output valid, status, expired_id, is_last, input ready);
  modport sink   (input valid, status, expired_id, is_last, output ready);
endinterface

>>> sv/stq_ram.sv
// stq_ram: single-port-write, registered-read store for sorted timer entries
// depends on nothing but its parameters
module stq_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned DW    = 56
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/stq_ctrl.sv
// stq_ctrl: sequencer that searches, shifts and pops the sorted store
// depends on stq_pkg and the channel interfaces
module stq_ctrl
  import stq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned ID_BITS     = ID_BITS_DEF,
  parameter int unsigned TIME_BITS   = TIME_BITS_DEF,
  localparam int unsigned AW = $clog2(QUEUE_DEPTH),
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned DW = TIME_BITS + ID_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  stq_in_if.sink        in_ch,
  stq_out_if.source     out_ch,
  output logic [AW-1:0] raddr,
  input  logic [DW-1:0] rdata,
  output logic          we,
  output logic [AW-1:0] waddr,
  output logic [DW-1:0] wdata
);

  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          idx_r, idx_nxt;
  logic [CW-1:0]          pos_r, pos_nxt;
  logic [CW-1:0]          occ_r, occ_nxt;
  logic [TIME_BITS-1:0]   clock_r, clock_nxt;
  logic [TIME_BITS-1:0]   when_r, when_nxt;
  logic [ID_BITS-1:0]     id_r, id_nxt;
  req_t                   req_r, req_nxt;
  logic                   found_r, found_nxt;
  logic [ID_BITS-1:0]     hold_r, hold_nxt;
  status_t                code_r, code_nxt;
  logic                   ovalid_r, ovalid_nxt;
  status_t                ostat_r, ostat_nxt;
  logic [7:0]             oid_r, oid_nxt;
  logic                   olast_r, olast_nxt;

  logic                   out_free;
  logic [TIME_BITS-1:0]   rd_time;
  logic [ID_BITS-1:0]     rd_id;
  logic [TIME_BITS:0]     sum_delay, sum_elap;
  logic [CW:0]            idx_inc;

  assign rd_time  = rdata[DW-1:ID_BITS];
  assign rd_id    = rdata[ID_BITS-1:0];
  assign out_free = !ovalid_r || out_ch.ready;
  assign idx_inc  = {1'b0, idx_r} + (CW+1)'(1);

  // saturating time sums
  assign sum_delay = {1'b0, clock_r} + (TIME_BITS+1)'(in_ch.delay_ms);
  assign sum_elap  = {1'b0, clock_r} + (TIME_BITS+1)'(in_ch.elapsed_ms);

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = ovalid_r;
  assign out_ch.status     = ostat_r;
  assign out_ch.expired_id = oid_r;
  assign out_ch.is_last    = olast_r;

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      occ_r    <= '0;
      clock_r  <= '0;
      ovalid_r <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      occ_r    <= occ_nxt;
      clock_r  <= clock_nxt;
      ovalid_r <= ovalid_nxt;
      found_r  <= found_nxt;
    end
  end

  // working and result payload registers
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    pos_r   <= pos_nxt;
    when_r  <= when_nxt;
    id_r    <= id_nxt;
    req_r   <= req_nxt;
    hold_r  <= hold_nxt;
    code_r  <= code_nxt;
    ostat_r <= ostat_nxt;
    oid_r   <= oid_nxt;
    olast_r <= olast_nxt;
  end

  // next state and outputs
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    occ_nxt    = occ_r;
    clock_nxt  = clock_r;
    when_nxt   = when_r;
    id_nxt     = id_r;
    req_nxt    = req_r;
    found_nxt  = found_r;
    hold_nxt   = hold_r;
    code_nxt   = code_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    ostat_nxt  = ostat_r;
    oid_nxt    = oid_r;
    olast_nxt  = olast_r;
    raddr      = idx_r[AW-1:0];
    we         = 1'b0;
    waddr      = idx_r[AW-1:0];
    wdata      = rdata;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          req_nxt   = req_t'(in_ch.req_type);
          id_nxt    = ID_BITS'(in_ch.timer_id);
          idx_nxt   = '0;
          found_nxt = 1'b0;
          when_nxt  = sum_delay[TIME_BITS] ? '1 : sum_delay[TIME_BITS-1:0];
          code_nxt  = ST_DONE;
          case (req_t'(in_ch.req_type))
            REQ_SCHEDULE, REQ_CANCEL: state_nxt = S_FIND_RD;
            REQ_POLL: begin
              clock_nxt = sum_elap[TIME_BITS] ? '1 : sum_elap[TIME_BITS-1:0];
              state_nxt = S_POLL_RD;
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end

      // linear search for the id
      S_FIND_RD: begin
        if (idx_r == occ_r) begin
          if (req_r == REQ_CANCEL) begin
            code_nxt  = ST_NOTFOUND;
            state_nxt = S_RESP;
          end else if (occ_r == DEPTH_C) begin
            code_nxt  = ST_FULL;
            state_nxt = S_RESP;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_POS_RD;
          end
        end else begin
          state_nxt = S_FIND_CHK;
        end
      end

      S_FIND_CHK: begin
        if (rd_id == id_r) begin
          state_nxt = S_DN_RD;
        end else begin
          idx_nxt   = idx_inc[CW-1:0];
          state_nxt = S_FIND_RD;
        end
      end

      // remove entry at idx by shifting the tail down
      S_DN_RD: begin
        raddr = idx_inc[AW-1:0];
        if (idx_inc >= {1'b0, occ_r}) begin
          occ_nxt = occ_r - CW'(1);
          idx_nxt = '0;
          if (req_r == REQ_SCHEDULE) begin
            state_nxt = S_POS_RD;
          end else if (req_r == REQ_POLL) begin
            state_nxt = S_POLL_RD;
          end else begin
            state_nxt = S_RESP;
          end
        end else begin
          state_nxt = S_DN_WR;
        end
      end

      S_DN_WR: begin
        we        = 1'b1;
        idx_nxt   = idx_inc[CW-1:0];
        state_nxt = S_DN_RD;
      end

      // find the insertion point behind equal or earlier expiries
      S_POS_RD: begin
        if (idx_r == occ_r) begin
          pos_nxt   = idx_r;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_POS_CHK;
        end
      end

      S_POS_CHK: begin
        if (rd_time <= when_r) begin
          idx_nxt   = idx_inc[CW-1:0];
          state_nxt = S_POS_RD;
        end else begin
          pos_nxt   = idx_r;
          idx_nxt   = occ_r;
          state_nxt = S_UP_RD;
        end
      end

      // open a gap at pos by shifting the tail up, then write the new entry
      S_UP_RD: begin
        raddr = AW'(idx_r - CW'(1));
        if (idx_r == pos_r) begin
          we        = 1'b1;
          wdata     = {when_r, id_r};
          occ_nxt   = occ_r + CW'(1);
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_UP_WR;
        end
      end

      S_UP_WR: begin
        we        = 1'b1;
        idx_nxt   = idx_r - CW'(1);
        state_nxt = S_UP_RD;
      end

      // pop expired entries from the head
      S_POLL_RD: begin
        raddr     = '0;
        state_nxt = S_POLL_CHK;
      end

      S_POLL_CHK: begin
        raddr = '0;
        if (occ_r != '0 && rd_time <= clock_r) begin
          if (!found_r || out_free) begin
            if (found_r) begin
              ovalid_nxt = 1'b1;
              ostat_nxt  = ST_EXPIRED;
              oid_nxt    = 8'(hold_r);
              olast_nxt  = 1'b0;
            end
            found_nxt = 1'b1;
            hold_nxt  = rd_id;
            idx_nxt   = '0;
            state_nxt = S_DN_RD;
          end
        end else if (out_free) begin
          ovalid_nxt = 1'b1;
          ostat_nxt  = found_r ? ST_EXPIRED : ST_NONE;
          oid_nxt    = found_r ? 8'(hold_r) : 8'd0;
          olast_nxt  = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      // single result for schedule, cancel or an unused code
      S_RESP: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          ostat_nxt  = code_r;
          oid_nxt    = 8'd0;
          olast_nxt  = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> sv/sorted_timer_queue_top.sv
// sorted_timer_queue_top: sorted timer queue with millisecond clock
// depends on stq_pkg, stq_if, stq_ram and stq_ctrl
//
// Usage: request items enter on in_ch (valid/ready); req_type selects
// schedule, cancel or poll. Each schedule, cancel or unused code gives one
// result item; a poll gives one item per expired timer in expiry order, the
// last marked by is_last, or a single "none expired" item.
// Timers live in one memory kept sorted, with a registered read port.
// The sequencer visits one entry at a time: a search over the
// queued entries, then a shift of the tail down (removal) or up (insert).
// One item is worked on at a time; in_ch.ready is high only between items.
// A finished result sits in the output register, so the next item is taken
// while it waits; a stalled receiver holds the sequencer only when a
// further result is due.
// Synchronous active-low reset empties the queue and zeroes the clock;
// no clearing pass is needed.
module sorted_timer_queue_top
  import stq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned ID_BITS     = ID_BITS_DEF,
  parameter int unsigned TIME_BITS   = TIME_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  stq_in_if.sink    in_ch,
  stq_out_if.source out_ch
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned DW = TIME_BITS + ID_BITS;

  logic [AW-1:0] raddr, waddr;
  logic [DW-1:0] rdata, wdata;
  logic          we;

  // sequencer
  stq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_BITS    (ID_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .raddr (raddr),
    .rdata (rdata),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata)
  );

  // sorted entry store
  stq_ram #(
    .DEPTH(QUEUE_DEPTH),
    .DW   (DW)
  ) u_ram (
    .clk  (clk),
    .raddr(raddr),
    .rdata(rdata),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata)
  );

endmodule

>>> tb/sorted_timer_queue_top_tb.sv
// sorted_timer_queue_top_tb: self-checking bench for the sorted timer queue
// depends on stq_pkg, stq_if (stq_in_if, stq_out_if) and sorted_timer_queue_top
`timescale 1ns / 100ps

module sorted_timer_queue_top_tb;
  import stq_pkg::*;

  localparam int unsigned DEPTH    = QUEUE_DEPTH_DEF;
  localparam int unsigned TBITS    = TIME_BITS_DEF;
  localparam logic [TBITS-1:0] TMAX = '1;
  localparam int unsigned IDLE_LIMIT = 20000;

  typedef struct packed {
    status_t    status;
    logic [7:0] expired_id;
    logic       is_last;
  } timer_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  stq_in_if  in_ch ();
  stq_out_if out_ch ();

  sorted_timer_queue_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #5 clk = ~clk;

  // shadow of the sorted store
  logic [TBITS-1:0] shadow_expiry[$];
  logic [7:0]       shadow_id[$];
  logic [TBITS-1:0] shadow_clock;
  timer_result_t    pending_results[$];

  int  fail_count;
  int  idle_cycles;
  int  send_idle_pct;
  int  recv_idle_pct;
  int  recv_hold;
  bit  timed_out;

  function automatic logic [TBITS-1:0] sat_sum(logic [TBITS-1:0] a, logic [63:0] b);
    logic [TBITS:0] s;
    s = {1'b0, a} + b[TBITS:0];
    return s[TBITS] ? TMAX : s[TBITS-1:0];
  endfunction

  function automatic int locate_id(logic [7:0] id);
    foreach (shadow_id[i]) if (shadow_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void push_result(status_t st, logic [7:0] id, logic last);
    timer_result_t r;
    r.status = st;
    r.expired_id = id;
    r.is_last = last;
    pending_results.push_back(r);
  endfunction

  // predicts the results of one request and updates the shadow store
  function automatic void predict_timer_request(req_t req, logic [7:0] id,
                                                logic [31:0] delay,
                                                logic [15:0] elapsed);
    int pos;
    int n;
    logic [TBITS-1:0] when;
    case (req)
      REQ_SCHEDULE: begin
        pos = locate_id(id);
        if (pos >= 0) begin
          shadow_expiry.delete(pos);
          shadow_id.delete(pos);
        end else if (shadow_id.size() >= DEPTH) begin
          push_result(ST_FULL, 8'd0, 1'b1);
          return;
        end
        when = sat_sum(shadow_clock, {32'd0, delay});
        pos = 0;
        while (pos < shadow_expiry.size() && shadow_expiry[pos] <= when) pos++;
        shadow_expiry.insert(pos, when);
        shadow_id.insert(pos, id);
        push_result(ST_DONE, 8'd0, 1'b1);
      end
      REQ_CANCEL: begin
        pos = locate_id(id);
        if (pos < 0) begin
          push_result(ST_NOTFOUND, 8'd0, 1'b1);
        end else begin
          shadow_expiry.delete(pos);
          shadow_id.delete(pos);
          push_result(ST_DONE, 8'd0, 1'b1);
        end
      end
      REQ_POLL: begin
        shadow_clock = sat_sum(shadow_clock, {48'd0, elapsed});
        n = 0;
        while (shadow_expiry.size() > 0 && shadow_expiry[0] <= shadow_clock) begin
          push_result(ST_EXPIRED, shadow_id[0], 1'b0);
          void'(shadow_expiry.pop_front());
          void'(shadow_id.pop_front());
          n++;
        end
        if (n == 0) push_result(ST_NONE, 8'd0, 1'b1);
        else pending_results[$].is_last = 1'b1;
      end
      default: push_result(ST_DONE, 8'd0, 1'b1);
    endcase
  endfunction

  // sends one item, predicting on acceptance; valid is dropped by the
  // next idle cycle or by the drain
  task automatic send_request(req_t req, logic [7:0] id, logic [31:0] delay,
                              logic [15:0] elapsed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= req;
    in_ch.timer_id   <= id;
    in_ch.delay_ms   <= delay;
    in_ch.elapsed_ms <= elapsed;
    do @(posedge clk); while (!in_ch.ready);
    predict_timer_request(req, id, delay, elapsed);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
  endtask

  // receiver side: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    timer_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: status %0d id %0d",
               out_ch.status, out_ch.expired_id);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.status !== exp_r.status) begin
          $error("status: expected %0d actual %0d", exp_r.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.expired_id !== exp_r.expired_id) begin
          $error("expired_id: expected %0d actual %0d", exp_r.expired_id,
                 out_ch.expired_id);
          fail_count++;
        end
        if (out_ch.is_last !== exp_r.is_last) begin
          $error("is_last: expected %0d actual %0d", exp_r.is_last, out_ch.is_last);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(REQ_POLL, 8'd0, 32'd0, 16'd0);              // empty poll
    send_request(REQ_CANCEL, 8'd7, 32'd0, 16'd0);            // missing id
    send_request(REQ_SCHEDULE, 8'd0, 32'd0, 16'd0);
    send_request(REQ_SCHEDULE, 8'd255, 32'hFFFF_FFFF, 16'd0);
    send_request(REQ_SCHEDULE, 8'h55, 32'd10, 16'd0);
    send_request(REQ_SCHEDULE, 8'hAA, 32'd10, 16'd0);        // equal expiry keeps order
    send_request(REQ_SCHEDULE, 8'h55, 32'd20, 16'd0);        // reschedule
    send_request(REQ_UNUSED, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF); // ignored code
    send_request(REQ_POLL, 8'd0, 32'd0, 16'd15);
    send_request(REQ_CANCEL, 8'd255, 32'd0, 16'd0);
    send_request(REQ_POLL, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
    drain_results();
    // fill the store, then a full-queue refusal and a bulk expiry
    for (int i = 0; i < DEPTH; i++)
      send_request(REQ_SCHEDULE, 8'(i + 1), 32'($urandom_range(50)), 16'd0);
    send_request(REQ_SCHEDULE, 8'd200, 32'd1, 16'd0);
    send_request(REQ_SCHEDULE, 8'd3, 32'd5, 16'd0);         // reschedule when full
    send_request(REQ_POLL, 8'd0, 32'd0, 16'd60);
  endtask

  task automatic test_random(int count);
    req_t        req;
    logic [31:0] delay;
    logic [15:0] elapsed;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: req = REQ_SCHEDULE;
        5, 6: req = REQ_CANCEL;
        7, 8: req = REQ_POLL;
        default: req = req_t'($urandom_range(3));
      endcase
      delay = ($urandom_range(15) == 0) ? $urandom : 32'($urandom_range(400));
      elapsed = ($urandom_range(15) == 0) ? 16'($urandom) : 16'($urandom_range(120));
      send_request(req, 8'($urandom_range(($urandom_range(3) == 0) ? 255 : 40)),
                   delay, elapsed);
    end
  endtask

  // receiver blocks for a long stretch while requests keep coming
  task automatic test_backpressure();
    recv_hold = 300;
    for (int i = 0; i < 10; i++)
      send_request(REQ_SCHEDULE, 8'($urandom_range(20)), 32'($urandom_range(30)), 16'd0);
    send_request(REQ_POLL, 8'd0, 32'd0, 16'd40);
    drain_results();
  endtask

  // schedule with the largest delay, then poll with the largest elapsed time
  task automatic test_saturation();
    send_request(REQ_SCHEDULE, 8'd9, 32'hFFFF_FFFF, 16'd0);
    for (int i = 0; i < 4; i++)
      send_request(REQ_POLL, 8'd0, 32'd0, 16'hFFFF);
    drain_results();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_POLL;
    in_ch.timer_id = '0;
    in_ch.delay_ms = '0;
    in_ch.elapsed_ms = '0;
    shadow_clock = '0;
    fail_count = 0;
    idle_cycles = 0;
    recv_hold = 0;
    timed_out = 1'b0;
    send_idle_pct = 25;
    recv_idle_pct = 67;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(45);
    drain_results();
    send_idle_pct = 67;
    recv_idle_pct = 25;
    test_backpressure();
    test_random(45);
    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(45);
    test_saturation();

    drain_results();
    repeat (300) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> filelist.f
sv/stq_pkg.sv
sv/stq_if.sv
sv/stq_ram.sv
sv/stq_ctrl.sv
sv/sorted_timer_queue_top.sv
tb/sorted_timer_queue_top_tb.sv
